/* design/assert_macros.svh */
// assertion macros included by quaternion_to_euler_angles.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define Q2E_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define Q2E_ASSERT_IMPL(lbl, ante, cons)
`define Q2E_ASSERT_RST(lbl, ante, cons)
`endif
`endif

/* design/q2e_pkg.sv */
// types, constants and the atan table for the quaternion to euler pipeline
package q2e_pkg;
    localparam int TERM_W = 35;
    localparam int XY_W   = 37;
    localparam int ANG_W  = 26;
    localparam int MAG_W  = 28;
    localparam int RAD_W  = 58;
    localparam int ROOT_W = 29;
    localparam int REM_W  = 32;
    localparam int ISQ_STAGES = RAD_W / 2;

    localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd268435456);
    localparam logic signed [ANG_W-1:0]  DEG90   = ANG_W'(64'sd5898240);
    localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
    localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } lane_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] sy;
        logic signed [TERM_W-1:0] cy;
        logic signed [TERM_W-1:0] sp;
        logic signed [TERM_W-1:0] sr;
        logic signed [TERM_W-1:0] cr;
        logic                     sat;
        logic                     sat_pos;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } isq_t;

    // atan(2^-i) in degrees * 2^16
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            5'd0:  r = ANG_W'(32'sd2949120);
            5'd1:  r = ANG_W'(32'sd1740967);
            5'd2:  r = ANG_W'(32'sd919879);
            5'd3:  r = ANG_W'(32'sd466945);
            5'd4:  r = ANG_W'(32'sd234379);
            5'd5:  r = ANG_W'(32'sd117304);
            5'd6:  r = ANG_W'(32'sd58666);
            5'd7:  r = ANG_W'(32'sd29335);
            5'd8:  r = ANG_W'(32'sd14668);
            5'd9:  r = ANG_W'(32'sd7334);
            5'd10: r = ANG_W'(32'sd3667);
            5'd11: r = ANG_W'(32'sd1833);
            5'd12: r = ANG_W'(32'sd917);
            5'd13: r = ANG_W'(32'sd458);
            5'd14: r = ANG_W'(32'sd229);
            5'd15: r = ANG_W'(32'sd115);
            5'd16: r = ANG_W'(32'sd57);
            5'd17: r = ANG_W'(32'sd29);
            5'd18: r = ANG_W'(32'sd14);
            5'd19: r = ANG_W'(32'sd7);
            5'd20: r = ANG_W'(32'sd4);
            5'd21: r = ANG_W'(32'sd2);
            5'd22: r = ANG_W'(32'sd1);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

/* design/quaternion_to_euler_angles.sv */
// the pipeline depth is set by the 29-stage square root
// and one register stage per cordic iteration
// throughput: one quaternion per cycle; the whole pipeline holds while a result waits
// reset: aresetn low clears every valid bit, payload registers keep their contents
// quaternion to zyx euler angles, pipelined cordic with a pipelined integer square root
`include "assert_macros.svh"
module quaternion_to_euler_angles
    import q2e_pkg::*;
#(
    parameter int QUAT_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // q_w, q_x, q_y, q_z, zero fill
    input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // yaw_deg, pitch_deg, roll_deg, zero fill
    output logic [47:0]           m_tdata,
    // pitch_saturated
    output logic [0:0]            m_tuser
);
    localparam int NST = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    logic ce;
    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic [0:0]  m_tuser_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---- stage 1: scale to q2.14 and form products
    logic signed [15:0] q14 [4];
    for (genvar k = 0; k < 4; k++) begin : g_in
        logic signed [QUAT_WIDTH-1:0] raw;
        assign raw = s_tdata[k*QUAT_WIDTH +: QUAT_WIDTH];
        if (QUAT_WIDTH >= 16) begin : g_down
            assign q14[k] = 16'(raw >>> (QUAT_WIDTH - 16));
        end else begin : g_up
            assign q14[k] = {raw, {(16-QUAT_WIDTH){1'b0}}};
        end
    end

    logic signed [31:0] prod_reg [9];
    logic v1_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg[0] <= q14[0] * q14[3];
            prod_reg[1] <= q14[1] * q14[2];
            prod_reg[2] <= q14[2] * q14[2];
            prod_reg[3] <= q14[3] * q14[3];
            prod_reg[4] <= q14[0] * q14[2];
            prod_reg[5] <= q14[3] * q14[1];
            prod_reg[6] <= q14[0] * q14[1];
            prod_reg[7] <= q14[2] * q14[3];
            prod_reg[8] <= q14[1] * q14[1];
        end
    end

    // ---- stage 2: sine and cosine terms
    side_t s2_reg;
    logic  v2_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_reg.sy <= (TERM_W'(prod_reg[0]) + TERM_W'(prod_reg[1])) <<< 1;
            s2_reg.cy <= ONE_Q28 - ((TERM_W'(prod_reg[2]) + TERM_W'(prod_reg[3])) <<< 1);
            s2_reg.sp <= (TERM_W'(prod_reg[4]) - TERM_W'(prod_reg[5])) <<< 1;
            s2_reg.sr <= (TERM_W'(prod_reg[6]) + TERM_W'(prod_reg[7])) <<< 1;
            s2_reg.cr <= ONE_Q28 - ((TERM_W'(prod_reg[8]) + TERM_W'(prod_reg[2])) <<< 1);
            s2_reg.sat     <= 1'b0;
            s2_reg.sat_pos <= 1'b0;
        end
    end

    // ---- stage 3: pitch saturation and magnitude
    side_t s3_reg;
    side_t s3_next;
    logic [MAG_W-1:0] mag_reg;
    logic v3_reg;
    logic sp_hi, sp_lo;
    logic signed [TERM_W-1:0] sp_abs;
    assign sp_hi  = s2_reg.sp >= ONE_Q28;
    assign sp_lo  = s2_reg.sp <= -ONE_Q28;
    assign sp_abs = s2_reg.sp[TERM_W-1] ? -s2_reg.sp : s2_reg.sp;
    always_comb begin
        s3_next         = s2_reg;
        s3_next.sat     = sp_hi || sp_lo;
        s3_next.sat_pos = sp_hi;
    end
    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_reg         <= s3_next;
            mag_reg        <= (sp_hi || sp_lo) ? '0 : sp_abs[MAG_W-1:0];
        end
    end

    // ---- stage 4: magnitude squared
    side_t s4_reg;
    logic [2*MAG_W-1:0] magsq_reg;
    logic v4_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_reg    <= s3_reg;
            magsq_reg <= mag_reg * mag_reg;
        end
    end

    // ---- stage 5: radicand 1 - s^2
    side_t s5_reg;
    logic [RAD_W-1:0] rad_reg;
    logic v5_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            s5_reg  <= s4_reg;
            rad_reg <= (RAD_W'(1) << 56) - RAD_W'(magsq_reg);
        end
    end

    // ---- square root, one result bit per stage
    isq_t  isq_reg  [ISQ_STAGES+1];
    side_t isd_reg  [ISQ_STAGES+1];
    logic  isv_reg  [ISQ_STAGES+1];
    assign isq_reg[0] = '{rad: rad_reg, rem: '0, root: '0};
    assign isd_reg[0] = s5_reg;
    assign isv_reg[0] = v5_reg;

    for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_isq
        logic [REM_W-1:0] rem_sh, trial;
        logic             take;
        assign rem_sh = {isq_reg[k].rem[REM_W-3:0], isq_reg[k].rad[RAD_W-1-2*k -: 2]};
        assign trial  = REM_W'({isq_reg[k].root, 2'b01});
        assign take   = rem_sh >= trial;
        always_ff @(posedge aclk) begin
            if (ce) begin
                isq_reg[k+1].rad  <= isq_reg[k].rad;
                isq_reg[k+1].rem  <= take ? rem_sh - trial : rem_sh;
                isq_reg[k+1].root <= {isq_reg[k].root[ROOT_W-2:0], take};
                isd_reg[k+1]      <= isd_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                isv_reg[k+1] <= 1'b0;
            end else if (ce) begin
                isv_reg[k+1] <= isv_reg[k];
            end
        end
    end

    // ---- cordic pre-rotation into the right half plane
    lane_t cor_reg [NST+1][3];
    logic  cv_reg  [NST+1];
    logic  csat_reg [NST+1];
    logic  cpos_reg [NST+1];

    function automatic lane_t prerot(input logic signed [XY_W-1:0] x,
                                     input logic signed [XY_W-1:0] y);
        lane_t l;
        l.zero = (x == '0) && (y == '0);
        l.x    = x;
        l.y    = y;
        l.ang  = '0;
        if (x[XY_W-1]) begin
            if (!y[XY_W-1]) begin
                l.x = y;
                l.y = -x;
                l.ang = DEG90;
            end else begin
                l.x = -y;
                l.y = x;
                l.ang = -DEG90;
            end
        end
        return l;
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            cor_reg[0][0] <= prerot(XY_W'(isd_reg[ISQ_STAGES].cy), XY_W'(isd_reg[ISQ_STAGES].sy));
            cor_reg[0][1] <= prerot(XY_W'({1'b0, isq_reg[ISQ_STAGES].root}),
                                    XY_W'(isd_reg[ISQ_STAGES].sp));
            cor_reg[0][2] <= prerot(XY_W'(isd_reg[ISQ_STAGES].cr), XY_W'(isd_reg[ISQ_STAGES].sr));
            csat_reg[0]   <= isd_reg[ISQ_STAGES].sat;
            cpos_reg[0]   <= isd_reg[ISQ_STAGES].sat_pos;
        end
    end

    // ---- cordic vectoring iterations, one per stage
    for (genvar i = 0; i < NST; i++) begin : g_cor
        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic signed [XY_W-1:0] dx, dy;
            logic                   pos;
            assign dx  = cor_reg[i][j].y >>> i;
            assign dy  = cor_reg[i][j].x >>> i;
            assign pos = !cor_reg[i][j].y[XY_W-1] && (cor_reg[i][j].y != '0);
            always_ff @(posedge aclk) begin
                if (ce) begin
                    cor_reg[i+1][j].zero <= cor_reg[i][j].zero;
                    if (pos) begin
                        cor_reg[i+1][j].x   <= cor_reg[i][j].x + dx;
                        cor_reg[i+1][j].y   <= cor_reg[i][j].y - dy;
                        cor_reg[i+1][j].ang <= cor_reg[i][j].ang + atan_entry(5'(i));
                    end else begin
                        cor_reg[i+1][j].x   <= cor_reg[i][j].x - dx;
                        cor_reg[i+1][j].y   <= cor_reg[i][j].y + dy;
                        cor_reg[i+1][j].ang <= cor_reg[i][j].ang - atan_entry(5'(i));
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                csat_reg[i+1] <= csat_reg[i];
                cpos_reg[i+1] <= cpos_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (ce) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end
    end

    // ---- rounding to degrees*128, wrap and clamp
    logic signed [17:0] deg [3];
    for (genvar j = 0; j < 3; j++) begin : g_rnd
        logic signed [ANG_W:0] a;
        assign a      = cor_reg[NST][j].zero ? '0 : (ANG_W+1)'(cor_reg[NST][j].ang) + 27'sd256;
        assign deg[j] = 18'(a >>> 9);
    end

    logic signed [17:0] yaw_w, pitch_c, roll_c;
    always_comb begin
        yaw_w = deg[0][17] ? deg[0] + FULL_TURN : deg[0];
        if (csat_reg[NST]) begin
            pitch_c = cpos_reg[NST] ? QUARTER_TURN : -QUARTER_TURN;
        end else if (deg[1] > QUARTER_TURN) begin
            pitch_c = QUARTER_TURN;
        end else if (deg[1] < -QUARTER_TURN) begin
            pitch_c = -QUARTER_TURN;
        end else begin
            pitch_c = deg[1];
        end
        if (deg[2] > HALF_TURN) begin
            roll_c = HALF_TURN;
        end else if (deg[2] < -HALF_TURN) begin
            roll_c = -HALF_TURN;
        end else begin
            roll_c = deg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {1'b0, roll_c[15:0], pitch_c[14:0], yaw_w[15:0]};
            m_tuser_reg <= csat_reg[NST];
        end
    end

    // valid bits of the fixed stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            cv_reg[0]    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            cv_reg[0]    <= isv_reg[ISQ_STAGES];
            m_tvalid_reg <= cv_reg[NST];
        end
    end

    `Q2E_ASSERT_IMPL(a_yaw_range, m_tvalid, m_tdata[15:0] < 16'd46080)
    `Q2E_ASSERT_IMPL(a_sat_pitch, m_tvalid && m_tuser[0], (m_tdata[30:16] == 15'd11520) || (m_tdata[30:16] == 15'h5300))
    `Q2E_ASSERT_IMPL(a_root_bound, isv_reg[ISQ_STAGES], isq_reg[ISQ_STAGES].root <= ROOT_W'(1) << 28)
    `Q2E_ASSERT_RST(a_reset_clear, !aresetn, !m_tvalid)
endmodule

/* tb/quaternion_to_euler_angles_tb.sv */
// testbench for quaternion_to_euler_angles: directed and random quaternions against a bit-true predictor
module quaternion_to_euler_angles_tb;
    import q2e_pkg::*;

    localparam int STEPS = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_LEN = 300;
    localparam longint ONE_Q28_L = 64'sd268435456;
    localparam longint DEG90_L = 64'sd5898240;
    localparam longint ATAN_DEG16 [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    typedef struct {
        logic [15:0] yaw;
        logic [14:0] pitch;
        logic [15:0] roll;
        logic        sat;
    } angles_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    angles_t angles_q[$];
    int      fail_count = 0;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles = 0;
    logic    hold_req = 1'b0;
    logic    hold_ack = 1'b0;
    int      quiet_cycles = 0;

    quaternion_to_euler_angles #(.QUAT_WIDTH(16), .CORDIC_STEPS(STEPS)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // vectoring cordic, angle in degrees * 2^16
    function automatic longint vector_angle(longint y, longint x);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; ang = DEG90_L;
            end else begin
                t = x; x = -y; y = t; ang = -DEG90_L;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; ang += ATAN_DEG16[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_DEG16[i];
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint deg128(longint a);
        return (a + 256) >>> 9;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic angles_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                         logic signed [15:0] qy, logic signed [15:0] qz);
        angles_t r;
        longint w, x, y, z, sy, cy, sp, sr, cr, yaw, pitch, roll, mag;
        w = qw; x = qx; y = qy; z = qz;
        r.sat = 1'b0;
        sy = 2 * (w * z + x * y);
        cy = ONE_Q28_L - 2 * (y * y + z * z);
        yaw = deg128(vector_angle(sy, cy));
        while (yaw < 0) yaw += 46080;
        while (yaw >= 46080) yaw -= 46080;
        sp = 2 * (w * y - z * x);
        if (sp >= ONE_Q28_L) begin
            pitch = 11520; r.sat = 1'b1;
        end else if (sp <= -ONE_Q28_L) begin
            pitch = -11520; r.sat = 1'b1;
        end else begin
            mag = sp < 0 ? -sp : sp;
            pitch = clamp_mag(deg128(vector_angle(sp,
                longint'(int_sqrt((64'd1 << 56) - mag * mag)))), 11520);
        end
        sr = 2 * (w * x + y * z);
        cr = ONE_Q28_L - 2 * (x * x + y * y);
        roll = clamp_mag(deg128(vector_angle(sr, cr)), 23040);
        r.yaw = yaw[15:0];
        r.pitch = pitch[14:0];
        r.roll = roll[15:0];
        return r;
    endfunction

    task automatic send_quat(int qw, int qx, int qy, int qz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {16'(qz), 16'(qy), 16'(qx), 16'(qw)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        angles_q.push_back(euler_of(16'(qw), 16'(qx), 16'(qy), 16'(qz)));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (angles_q.size() != 0) @(negedge aclk);
    endtask

    task automatic send_random_quat();
        int  pick;
        int  c [4];
        real a [4];
        real n;
        pick = $urandom_range(99);
        if (pick < 70) begin
            // unit quaternion with random orientation
            do begin
                n = 0.0;
                for (int i = 0; i < 4; i++) begin
                    a[i] = real'(int'($urandom_range(2000)) - 1000);
                    n += a[i] * a[i];
                end
            end while (n < 1.0);
            n = $sqrt(n);
            for (int i = 0; i < 4; i++) c[i] = $rtoi(a[i] / n * 16384.0);
        end else if (pick < 88) begin
            for (int i = 0; i < 4; i++) c[i] = int'($urandom_range(32768)) - 16384;
        end else begin
            // near gimbal lock, pitch sine close to plus or minus one
            c[0] = 11585 + int'($urandom_range(40)) - 20;
            c[2] = ($urandom_range(1) ? 1 : -1) * (11585 + int'($urandom_range(40)) - 20);
            c[1] = int'($urandom_range(200)) - 100;
            c[3] = int'($urandom_range(200)) - 100;
            if ($urandom_range(1)) c[0] = -c[0];
        end
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    task automatic test_directed();
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, -16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, -16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, -16384);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(16384, -16384, 16384, -16384);
        send_quat(16384, 0, 16384, 0);
        send_quat(16384, 0, -16384, 0);
        send_quat(8192, 0, 16384, 0);
        send_quat(8192, 0, -16384, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 0, 0, 11585);
        send_quat(11585, 0, 0, -11585);
        send_quat(11585, 11585, 0, 0);
        send_quat(-11585, 11585, 0, 0);
        send_quat(8192, 8192, 8192, -8192);
        send_quat(16383, -1, 1, -16383);
        wait_drained();
    endtask

    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) send_random_quat();
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = ~hold_req;
        repeat (110) send_random_quat();
        wait_drained();
    endtask

    // receiver: a long hold on request, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cycles <= HOLD_LEN - 1;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        angles_t exp_a;
        if (aresetn && m_tvalid && m_tready) begin
            if (angles_q.size() == 0) begin
                $error("result beat with no quaternion outstanding");
                fail_count++;
            end else begin
                exp_a = angles_q.pop_front();
                if (m_tdata[15:0] !== exp_a.yaw) begin
                    $error("yaw_deg expected %0d got %0d", exp_a.yaw, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[30:16] !== exp_a.pitch) begin
                    $error("pitch_deg expected %0d got %0d",
                           $signed(exp_a.pitch), $signed(m_tdata[30:16]));
                    fail_count++;
                end
                if (m_tdata[46:31] !== exp_a.roll) begin
                    $error("roll_deg expected %0d got %0d",
                           $signed(exp_a.roll), $signed(m_tdata[46:31]));
                    fail_count++;
                end
                if (m_tuser[0] !== exp_a.sat) begin
                    $error("pitch_saturated expected %0d got %0d", exp_a.sat, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(240, 0, 0);
        test_random(230, 50, 0);
        test_random(230, 0, 50);
        test_random(230, 8, 8);
        test_backpressure();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && angles_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/q2e_pkg.sv
design/quaternion_to_euler_angles.sv
tb/quaternion_to_euler_angles_tb.sv
